// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the matrix inverse RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define M4I_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define M4I_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define M4I_ASSERT(lbl, clk, rstn, prop, msg)
`define M4I_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ----- hdl/m4i_pkg.sv -----
// Types, constants and helper functions for the 4x4 matrix inverse
`timescale 1ns / 1ps
package m4i_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 32;
    localparam int WIDE_W        = 64;
    localparam int ACC_W         = 98;
    localparam int IDX_W         = 4;
    localparam int ADDR_W        = 3;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_INVERT  = 1'b1;
    localparam logic REG_DET_THR = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RA,
        ST_RB,
        ST_MAB,
        ST_LO,
        ST_HI,
        ST_ACC,
        ST_CF_WR,
        ST_D_RD,
        ST_D_LD,
        ST_DET_WR,
        ST_SING,
        ST_V_RD,
        ST_V_LD,
        ST_V_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic neg;
    } div_ctl_t;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [ELEM_W-1:0] value;
    } div_res_t;

    // column order {slot0, slot1, slot2} of each 3x3 permutation term
    function automatic logic [5:0] perm_cols(input logic [2:0] p);
        logic [5:0] r;
        unique case (p)
            3'd0:    r = {2'd0, 2'd1, 2'd2};
            3'd1:    r = {2'd1, 2'd2, 2'd0};
            3'd2:    r = {2'd2, 2'd0, 2'd1};
            3'd3:    r = {2'd0, 2'd2, 2'd1};
            3'd4:    r = {2'd2, 2'd1, 2'd0};
            3'd5:    r = {2'd1, 2'd0, 2'd2};
            default: r = {2'd0, 2'd1, 2'd2};
        endcase
        return r;
    endfunction

    // n-th index of 0..3 with excl left out
    function automatic logic [1:0] skip_idx(input logic [1:0] excl, input logic [1:0] n);
        return (n >= excl) ? n + 2'd1 : n;
    endfunction

endpackage

// ----- hdl/m4i_divider.sv -----
// Restoring bit-serial divider with Q-format scaling and 32-bit saturation
`timescale 1ns / 1ps
module m4i_divider #(
    parameter int FRAC_BITS = m4i_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  m4i_pkg::div_ctl_t              ctl,
    input  logic [m4i_pkg::WIDE_W-1:0]     num_mag,
    input  logic [m4i_pkg::WIDE_W-1:0]     den_mag,
    output m4i_pkg::div_res_t              res
);
    import m4i_pkg::*;

    localparam int NUM_W = WIDE_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] den_reg;
    logic [ELEM_W-1:0] q_reg;
    logic              big_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [WIDE_W:0]   rem_sh;
    logic [WIDE_W:0]   rem_sub;
    logic              ge;
    logic [ELEM_W:0]   q_wide;
    logic [ELEM_W-1:0] lim;
    logic              sat;
    logic [ELEM_W-1:0] q_clip;

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign q_wide  = {q_reg, ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (ctl.start)
                busy_reg <= 1'b1;
            else if (busy_reg && (cnt_reg == CNT_W'(1)))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            num_reg <= {num_mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den_mag;
            q_reg   <= '0;
            big_reg <= 1'b0;
            neg_reg <= ctl.neg;
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? rem_sub[WIDE_W-1:0] : rem_sh[WIDE_W-1:0];
            q_reg   <= q_wide[ELEM_W-1:0];
            big_reg <= big_reg | q_wide[ELEM_W];
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign lim    = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign sat    = big_reg || (q_reg > lim);
    assign q_clip = sat ? lim : q_reg;

    assign res.done  = done_reg;
    assign res.sat   = sat;
    assign res.value = neg_reg ? (~q_clip + 32'd1) : q_clip;

endmodule

// ----- hdl/matrix4_inverse_cofactor.sv -----
// Top level: 4x4 fixed-point matrix inverse by adjugate and determinant
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A load (cmd 0) writes one element and is taken every cycle while idle. An
// invert command (cmd 1) runs the whole inversion on one shared 33x33 signed
// multiplier and one bit-serial divider, with in_ready low until the last of
// the 16 results is taken: first 16 cofactors of 6 terms each, each written
// after its last term, then the determinant, then per result a divide of the
// cofactor by the determinant (identity results, when singular, skip the
// divider). Output stalls hold the run.
module matrix4_inverse_cofactor #(
    parameter int FRAC_BITS = m4i_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [m4i_pkg::IDX_W-1:0]    elem_index,
    input  logic signed [m4i_pkg::ELEM_W-1:0] elem_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [m4i_pkg::IDX_W-1:0]    out_index,
    output logic signed [m4i_pkg::ELEM_W-1:0] out_value,
    output logic                         singular,
    output logic                         saturated,
    output logic                         last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [m4i_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import m4i_pkg::*;

    localparam logic [ELEM_W-1:0] ONE_Q = ELEM_W'(1) << FRAC_BITS;

    state_t state_reg, state_next;

    logic [ELEM_W-1:0] mat_mem [16];
    logic [WIDE_W-1:0] cof_mem [16];
    logic [ELEM_W-1:0] m_rd_reg;
    logic [WIDE_W-1:0] cof_rd_reg;

    logic [30:0]       thr_reg;
    logic [IDX_W-1:0]  o_reg,  o_next;
    logic [2:0]        p_reg,  p_next;
    logic [1:0]        k_reg,  k_next;
    logic              det_phase_reg, det_phase_next;
    logic              sing_reg;
    logic [WIDE_W-1:0] det_reg;
    logic [WIDE_W-1:0] md_reg;
    logic [ELEM_W-1:0] op_a_reg;
    logic [WIDE_W-1:0] ab_reg;
    logic signed [65:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [IDX_W-1:0]  out_index_reg;
    logic [ELEM_W-1:0] out_value_reg;
    logic              out_sat_reg;

    logic [1:0]        orow, ocol;
    logic [5:0]        pc;
    logic [IDX_W-1:0]  addr_a, addr_b, addr_c, mat_addr, cof_addr;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [ACC_W-1:0] addend, sh;
    logic              sub;
    logic              fits;
    logic [WIDE_W-1:0] shsat;
    logic [WIDE_W-1:0] det_mag;
    logic [WIDE_W-1:0] cof_mag;
    logic              cfg_wr;
    div_ctl_t          div_ctl;
    div_res_t          div_res;

    assign orow   = o_reg[1:0];
    assign ocol   = o_reg[3:2];
    assign pc     = perm_cols(p_reg);
    assign addr_a = {skip_idx(orow, pc[5:4]), skip_idx(ocol, 2'd0)};
    assign addr_b = {skip_idx(orow, pc[3:2]), skip_idx(ocol, 2'd1)};
    assign addr_c = {skip_idx(orow, pc[1:0]), skip_idx(ocol, 2'd2)};

    always_comb
    begin
        if (det_phase_reg)
            mat_addr = {2'b00, k_reg};
        else if (state_reg == ST_RA)
            mat_addr = addr_a;
        else if (state_reg == ST_RB)
            mat_addr = addr_b;
        else
            mat_addr = addr_c;
    end

    assign cof_addr = det_phase_reg ? {k_reg, 2'b00} : o_reg;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DET_THR);
    assign prdata = (paddr[2] == REG_DET_THR) ? {1'b0, thr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_wr)
            thr_reg <= pwdata[30:0];
    end

    // element and cofactor stores
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && cmd == CMD_LOAD)
            mat_mem[elem_index] <= elem_value;
        m_rd_reg <= mat_mem[mat_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CF_WR)
            cof_mem[o_reg] <= shsat;
        cof_rd_reg <= cof_mem[cof_addr];
    end

    // shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_MAB:  mul_a = {op_a_reg[ELEM_W-1], op_a_reg};
            ST_LO:   mul_a = {1'b0, ab_reg[31:0]};
            default: mul_a = {ab_reg[63], ab_reg[63:32]};
        endcase
    end
    assign mul_b = {m_rd_reg[ELEM_W-1], m_rd_reg};
    assign mul_p = mul_a * mul_b;

    assign sub    = !det_phase_reg && ((p_reg >= 3'd3) ^ orow[0] ^ ocol[0]);
    assign addend = (state_reg == ST_ACC) ? (ACC_W'(prod_reg) <<< 32) : ACC_W'(prod_reg);
    assign sh     = acc_reg >>> FRAC_BITS;
    assign fits   = (&sh[ACC_W-1:63]) || !(|sh[ACC_W-1:63]);
    assign shsat  = fits ? sh[63:0]
                  : (acc_reg[ACC_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);
    assign det_mag = det_reg[63] ? (~det_reg + 64'd1) : det_reg;
    assign cof_mag = cof_rd_reg[63] ? (~cof_rd_reg + 64'd1) : cof_rd_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RB)
            op_a_reg <= m_rd_reg;
        if (state_reg == ST_MAB)
            ab_reg <= mul_p[63:0];
        else if (state_reg == ST_D_LD)
            ab_reg <= cof_rd_reg;
        if (state_reg == ST_LO || state_reg == ST_HI)
            prod_reg <= mul_p;
        if (state_reg == ST_IDLE || state_reg == ST_CF_WR)
            acc_reg <= '0;
        else if (state_reg == ST_HI || state_reg == ST_ACC)
            acc_reg <= sub ? acc_reg - addend : acc_reg + addend;
        if (state_reg == ST_SING)
            md_reg <= det_mag;
    end

    assign div_ctl.start = (state_reg == ST_V_LD);
    assign div_ctl.neg   = cof_rd_reg[63] ^ det_reg[63];

    m4i_divider #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (div_ctl),
        .num_mag (cof_mag),
        .den_mag (md_reg),
        .res     (div_res)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_V_RD && sing_reg)
        begin
            out_index_reg <= o_reg;
            out_value_reg <= (orow == ocol) ? ONE_Q : '0;
            out_sat_reg   <= 1'b0;
        end
        else if (state_reg == ST_V_DIV && div_res.done)
        begin
            out_index_reg <= o_reg;
            out_value_reg <= div_res.value;
            out_sat_reg   <= div_res.sat;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            o_reg         <= '0;
            p_reg         <= '0;
            k_reg         <= '0;
            det_phase_reg <= 1'b0;
            sing_reg      <= 1'b0;
            det_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            o_reg         <= o_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
            det_phase_reg <= det_phase_next;
            if (state_reg == ST_DET_WR)
                det_reg <= shsat;
            if (state_reg == ST_SING)
                sing_reg <= det_mag <= (WIDE_W'(thr_reg) << FRAC_BITS);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        o_next         = o_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        det_phase_next = det_phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && cmd == CMD_INVERT)
                begin
                    o_next         = '0;
                    p_next         = '0;
                    det_phase_next = 1'b0;
                    state_next     = ST_RA;
                end
            end
            ST_RA:  state_next = ST_RB;
            ST_RB:  state_next = ST_MAB;
            ST_MAB: state_next = ST_LO;
            ST_LO:  state_next = ST_HI;
            ST_HI:  state_next = ST_ACC;
            ST_ACC:
            begin
                if (det_phase_reg)
                begin
                    if (k_reg == 2'd3)
                        state_next = ST_DET_WR;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_D_RD;
                    end
                end
                else if (p_reg == 3'd5)
                    state_next = ST_CF_WR;
                else
                begin
                    p_next     = p_reg + 3'd1;
                    state_next = ST_RA;
                end
            end
            ST_CF_WR:
            begin
                p_next = '0;
                if (o_reg == 4'd15)
                begin
                    o_next         = '0;
                    k_next         = '0;
                    det_phase_next = 1'b1;
                    state_next     = ST_D_RD;
                end
                else
                begin
                    o_next     = o_reg + 4'd1;
                    state_next = ST_RA;
                end
            end
            ST_D_RD:   state_next = ST_D_LD;
            ST_D_LD:   state_next = ST_LO;
            ST_DET_WR: state_next = ST_SING;
            ST_SING:
            begin
                det_phase_next = 1'b0;
                o_next         = '0;
                state_next     = ST_V_RD;
            end
            ST_V_RD:   state_next = sing_reg ? ST_OUT : ST_V_LD;
            ST_V_LD:   state_next = ST_V_DIV;
            ST_V_DIV:
            begin
                if (div_res.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (o_reg == 4'd15)
                    begin
                        o_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        o_next     = o_reg + 4'd1;
                        state_next = ST_V_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign singular  = sing_reg;
    assign saturated = out_sat_reg;
    assign last      = (out_index_reg == 4'd15);

    `M4I_ASSERT(a_last_to_idle, clk, rst_n, out_valid && out_ready && last |=> in_ready, "no idle after last transfer")
    `M4I_ASSERT_NEVER(a_in_out_excl, clk, rst_n, in_ready && out_valid, "input taken while result pending")
    `M4I_ASSERT(a_sing_no_sat, clk, rst_n, out_valid && singular |-> !saturated, "saturated on identity result")
    `M4I_ASSERT(a_mid_run_busy, clk, rst_n, out_valid && out_ready && !last |=> !in_ready, "idle before run end")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the 4x4 fixed-point matrix inverse
`timescale 1ns / 1ps
module tb_top;
    import m4i_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int WATCH_LIMIT = 40000;

    typedef struct packed {
        logic              cmd;
        logic [3:0]        idx;
        logic [31:0]       val;
    } mat_op_t;

    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] val;
        logic        sing;
        logic        sat;
        logic        last;
    } inv_elem_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready, cmd;
    logic [3:0] elem_index;
    logic signed [31:0] elem_value;
    logic out_valid, out_ready;
    logic [3:0] out_index;
    logic signed [31:0] out_value;
    logic singular, saturated, last;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    matrix4_inverse_cofactor DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .elem_index(elem_index), .elem_value(elem_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_index(out_index), .out_value(out_value),
        .singular(singular), .saturated(saturated), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mat_op_t   op_q[$];
    inv_elem_t inv_q[$];
    int        errors = 0;
    int        gap_cnt = 0;
    int        stall_cnt = 0;
    int        hold_req = 0;
    int        hold_done = 0;
    bit        no_idle = 0;
    int        idle_cycles = 0;

    logic signed [31:0] mat_model[16];
    logic signed [63:0] cof_model[16];
    logic signed [63:0] det_model;
    logic [30:0]        thr_model;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic signed [63:0] shift_sat(input logic signed [127:0] a);
        logic signed [127:0] s;
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        s = a >>> FB;
        hi_lim = 128'sh7FFF_FFFF_FFFF_FFFF;
        lo_lim = -hi_lim - 1;
        if (s > hi_lim)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < lo_lim)
            return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    function automatic void invert_predict(input logic c, input logic [3:0] idx,
                                           input logic signed [31:0] v);
        int perm[6][3];
        int rows[3];
        int cols[3];
        int nr, nc, orow, ocol;
        logic signed [127:0] acc, term, e3;
        logic signed [63:0] ab;
        logic [127:0] md, mn, q, lim, thr_w;
        logic neg, sing, sat;
        inv_elem_t r;
        if (c == CMD_LOAD)
        begin
            mat_model[idx] = v;
            return;
        end
        perm = '{'{0, 1, 2}, '{1, 2, 0}, '{2, 0, 1}, '{0, 2, 1}, '{2, 1, 0}, '{1, 0, 2}};
        for (int o = 0; o < 16; o++)
        begin
            orow = o & 3;
            ocol = o >> 2;
            nr = 0;
            nc = 0;
            for (int t = 0; t < 4; t++)
            begin
                if (t != ocol) begin rows[nr] = t; nr++; end
                if (t != orow) begin cols[nc] = t; nc++; end
            end
            acc = 0;
            for (int p = 0; p < 6; p++)
            begin
                ab = 64'(mat_model[cols[perm[p][0]] * 4 + rows[0]])
                     * 64'(mat_model[cols[perm[p][1]] * 4 + rows[1]]);
                term = ab;
                e3 = mat_model[cols[perm[p][2]] * 4 + rows[2]];
                term = term * e3;
                acc = (p < 3) ? acc + term : acc - term;
            end
            if ((orow + ocol) & 1)
                acc = -acc;
            cof_model[o] = shift_sat(acc);
        end
        acc = 0;
        for (int k = 0; k < 4; k++)
        begin
            term = cof_model[k * 4];
            e3 = mat_model[k];
            acc = acc + term * e3;
        end
        det_model = shift_sat(acc);
        acc = det_model;
        md = (acc < 0) ? -acc : acc;
        thr_w = 128'(thr_model) << FB;
        sing = (md <= thr_w);
        for (int o = 0; o < 16; o++)
        begin
            r.idx = 4'(o);
            r.sing = sing;
            r.last = (o == 15);
            r.sat = 1'b0;
            if (sing)
                r.val = ((o % 5) == 0) ? (32'd1 << FB) : 32'd0;
            else
            begin
                acc = cof_model[o];
                mn = (acc < 0) ? -acc : acc;
                neg = (cof_model[o] < 0) != (det_model < 0);
                q = (mn << FB) / md;
                lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                sat = q > lim;
                if (sat)
                    q = lim;
                if (neg)
                    q = -q;
                r.val = q[31:0];
                r.sat = sat;
            end
            inv_q.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        mat_op_t nxt;
        logic taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_LOAD;
            elem_index <= '0;
            elem_value <= '0;
            gap_cnt <= 0;
        end
        else
        begin
            taken = in_valid && in_ready;
            if (taken)
                invert_predict(cmd, elem_index, elem_value);
            if (!in_valid || taken)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt <= gap_cnt - 1;
                    in_valid <= 1'b0;
                end
                else if (op_q.size() > 0)
                begin
                    nxt = op_q.pop_front();
                    cmd <= nxt.cmd;
                    elem_index <= nxt.idx;
                    elem_value <= nxt.val;
                    in_valid <= 1'b1;
                    if (no_idle || $urandom_range(0, 9) < 6)
                        gap_cnt <= 0;
                    else if ($urandom_range(0, 9) < 8)
                        gap_cnt <= $urandom_range(1, 3);
                    else
                        gap_cnt <= $urandom_range(5, 40);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        inv_elem_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (inv_q.size() == 0)
                report_mismatch("unexpected transfer", 64'(out_index), 64'd0);
            else
            begin
                w = inv_q.pop_front();
                if (out_index !== w.idx)
                    report_mismatch("out_index", 64'(out_index), 64'(w.idx));
                if (out_value !== w.val)
                    report_mismatch("out_value", 64'(unsigned'(out_value)), 64'(w.val));
                if (singular !== w.sing)
                    report_mismatch("singular", 64'(singular), 64'(w.sing));
                if (saturated !== w.sat)
                    report_mismatch("saturated", 64'(saturated), 64'(w.sat));
                if (last !== w.last)
                    report_mismatch("last", 64'(last), 64'(w.last));
            end
        end
    end

    // output backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_cnt <= 0;
        end
        else if (hold_done < hold_req)
        begin
            hold_done <= hold_done + 1;
            stall_cnt <= 3000;
            out_ready <= 1'b0;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt <= stall_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (no_idle || $urandom_range(0, 99) < 75)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= 1'b0;
            stall_cnt <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                    : $urandom_range(10, 60);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_op(input logic c, input logic [3:0] i, input logic [31:0] v);
        mat_op_t m;
        m.cmd = c;
        m.idx = i;
        m.val = v;
        op_q.push_back(m);
    endtask

    task automatic wait_drain();
        while (op_q.size() != 0 || in_valid || gap_cnt != 0 || inv_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * REG_DET_THR);
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        thr_model = v[30:0];
        @(posedge clk);
    endtask

    function automatic logic [31:0] gen_value(input int mode, input int pos);
        logic [31:0] x;
        case (mode)
            0: x = $urandom_range(0, 1 << 19) - (1 << 18);
            1: x = $urandom;
            2: x = ((pos % 5) == 0) ? $urandom_range(1 << 17, 1 << 20)
                                    : $urandom_range(0, 1 << 15) - (1 << 14);
            3: x = $urandom_range(0, 1 << 11) - (1 << 10);
            default:
                case ($urandom_range(0, 4))
                    0: x = 32'h7FFF_FFFF;
                    1: x = 32'h8000_0000;
                    2: x = 32'hFFFF_FFFF;
                    3: x = 32'd1 << FB;
                    default: x = 32'd0;
                endcase
        endcase
        return x;
    endfunction

    task automatic push_matrix(input int mode);
        int order[16];
        for (int i = 0; i < 16; i++)
            order[i] = i;
        order.shuffle();
        for (int i = 0; i < 16; i++)
            push_op(CMD_LOAD, 4'(order[i]), gen_value(mode, order[i]));
    endtask

    initial
    begin
        int n_items;
        int phase;
        int pick;
        logic [31:0] thr_pick;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        thr_model = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_threshold(32'h8000_0000);

        // identity, then extremes and stray fields on invert
        for (int i = 0; i < 16; i++)
            push_op(CMD_LOAD, 4'(i), ((i % 5) == 0) ? (32'd1 << FB) : 32'd0);
        push_op(CMD_INVERT, 4'hF, 32'hFFFF_FFFF);
        push_op(CMD_LOAD, 4'd0, 32'h7FFF_FFFF);
        push_op(CMD_LOAD, 4'd5, 32'h8000_0000);
        push_op(CMD_LOAD, 4'd15, 32'hFFFF_FFFF);
        push_op(CMD_LOAD, 4'd4, 32'h0000_0001);
        push_op(CMD_INVERT, 4'h0, 32'h0);
        push_op(CMD_LOAD, 4'd10, 32'h0);
        push_op(CMD_INVERT, 4'hA, 32'h5555_AAAA);
        n_items = 24;
        wait_drain();

        phase = 0;
        while (n_items < 350)
        begin
            if (phase % 4 == 3)
            begin
                case ($urandom_range(0, 4))
                    0: thr_pick = 32'h0;
                    1: thr_pick = 32'h7FFF_FFFF;
                    2: thr_pick = 32'd1 << FB;
                    3: thr_pick = $urandom_range(0, 64);
                    default: thr_pick = $urandom;
                endcase
                thr_pick[31] = $urandom_range(0, 1);
                write_threshold(thr_pick);
            end
            no_idle = ($urandom_range(0, 5) == 0);
            if (phase == 6)
                hold_req++;
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                push_matrix($urandom_range(0, 4));
                push_op(CMD_INVERT, 4'($urandom), $urandom);
                n_items += 17;
            end
            else if (pick < 9)
            begin
                for (int i = $urandom_range(1, 5); i > 0; i--)
                begin
                    push_op(CMD_LOAD, 4'($urandom), $urandom);
                    n_items++;
                end
                push_op(CMD_INVERT, 4'($urandom), $urandom);
                n_items++;
            end
            else
            begin
                for (int i = $urandom_range(1, 6); i > 0; i--)
                begin
                    push_op(CMD_LOAD, 4'($urandom), gen_value(0, i));
                    n_items++;
                end
            end
            // keep the sender busy while the receiver holds off
            if (phase == 6)
            begin
                push_matrix(2);
                push_op(CMD_INVERT, 4'd0, 32'd0);
                push_matrix(0);
                push_op(CMD_INVERT, 4'd0, 32'd0);
                n_items += 34;
            end
            wait_drain();
            phase++;
        end

        no_idle = 1'b0;
        wait_drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- matrix4_inverse_cofactor.f -----
+incdir+hdl
hdl/m4i_pkg.sv
hdl/m4i_divider.sv
hdl/matrix4_inverse_cofactor.sv
tb/tb_top.sv
